### hw/rtl/chtb_pkg.sv
// chtb_pkg: types, codes and defaults shared by the canonical huffman table builder
// no dependencies; imported by every module of the block

package chtb_pkg;

  localparam int DEF_MAX_CODE_LENGTH = 16;
  localparam int DEF_SYMBOL_COUNT    = 256;
  localparam int CMD_QUEUE_DEPTH     = 2;

  // request operation codes
  localparam logic [1:0] OP_CLEAR     = 2'd0;
  localparam logic [1:0] OP_SET_COUNT = 2'd1;
  localparam logic [1:0] OP_APPEND    = 2'd2;
  localparam logic [1:0] OP_LOOKUP    = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_OVERFULL  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] length_index;
    logic [7:0] count_value;
    logic [7:0] symbol_value;
  } request_t;

  typedef struct packed {
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [1:0]  status;
  } result_t;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_ACK,
    CMD_REJECT,
    CMD_CLEAR,
    CMD_SET_COUNT,
    CMD_APPEND,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] length_index;
    logic [7:0] count_value;
    logic [7:0] symbol_value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SKIP,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic       skipping;
    logic       reading;
    logic [4:0] cur_len;
  } back_status_t;

endpackage

### hw/rtl/chtb_queue.sv
// chtb_queue: short command queue between front and back
// depends on chtb_pkg (cmd_t, CMD_QUEUE_DEPTH)

module chtb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  chtb_pkg::cmd_t wr_data,
  output logic          full,
  output logic          rd_valid,
  input  logic          rd_en,
  output chtb_pkg::cmd_t rd_data
);
  import chtb_pkg::*;

  localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t             slots [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(CMD_QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (!wr_en && rd_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### hw/rtl/chtb_front.sv
// chtb_front: accepts request beats, classifies them and queues commands
// depends on chtb_pkg and chtb_queue

module chtb_front #(
  parameter int MAX_CODE_LENGTH = chtb_pkg::DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = chtb_pkg::DEF_SYMBOL_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  chtb_pkg::request_t request,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output chtb_pkg::cmd_t     cmd
);
  import chtb_pkg::*;

  cmd_t cls;
  logic len_ok;
  logic sym_ok;
  logic accept;

  assign len_ok = (request.length_index != 5'd0) &&
                  (request.length_index <= 5'(MAX_CODE_LENGTH));
  assign sym_ok = ({1'b0, request.symbol_value} < 9'(SYMBOL_COUNT));
  assign accept = push && !full;

  always_comb begin
    cls.length_index = request.length_index;
    cls.count_value  = request.count_value;
    cls.symbol_value = request.symbol_value;
    unique case (request.operation)
      OP_CLEAR:     cls.kind = CMD_CLEAR;
      OP_SET_COUNT: cls.kind = len_ok ? CMD_SET_COUNT : CMD_ACK;
      OP_APPEND:    cls.kind = sym_ok ? CMD_APPEND : CMD_REJECT;
      OP_LOOKUP:    cls.kind = sym_ok ? CMD_LOOKUP : CMD_REJECT;
      default:      cls.kind = CMD_ACK;
    endcase
  end

  chtb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (cls),
    .full     (full),
    .rd_valid (cmd_valid),
    .rd_en    (cmd_take),
    .rd_data  (cmd)
  );

endmodule

### hw/rtl/chtb_back.sv
// chtb_back: executes commands against the count table and the code store
// depends on chtb_pkg; holds the code memory and the result register

module chtb_back #(
  parameter int MAX_CODE_LENGTH = chtb_pkg::DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = chtb_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  chtb_pkg::cmd_t         cmd,
  output logic                  cmd_take,
  output logic                  empty,
  input  logic                  pop,
  output chtb_pkg::result_t      result,
  output chtb_pkg::back_status_t stat
);
  import chtb_pkg::*;

  localparam int LEN_IDX_W = $clog2(MAX_CODE_LENGTH);
  localparam int SYM_W     = $clog2(SYMBOL_COUNT);

  back_state_t state, state_next;

  logic [7:0]              counts [MAX_CODE_LENGTH];
  logic [4:0]              cur_len;
  logic [7:0]              used;
  logic [16:0]             next_code;
  logic [SYMBOL_COUNT-1:0] valid_bits;
  logic [20:0]             mem [SYMBOL_COUNT];
  logic [20:0]             rd_entry;
  logic                    rd_hit;
  logic [SYM_W-1:0]        sym_reg;
  logic                    res_valid;

  logic       len_live;
  logic [7:0] cnt_cur;
  logic       exhausted;
  logic       overfull;
  logic       res_free;
  logic       do_clear;
  logic       do_set;
  logic       rd_en;
  logic       advance;
  logic       assign_code;
  logic       res_load;
  result_t    res_next;

  assign len_live  = (cur_len <= 5'(MAX_CODE_LENGTH));
  assign cnt_cur   = len_live ? counts[LEN_IDX_W'(cur_len - 5'd1)] : 8'd0;
  assign exhausted = len_live && (used >= cnt_cur);
  assign overfull  = !len_live || ((next_code >> cur_len) != 17'd0);
  assign res_free  = !res_valid || pop;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && res_free) begin
          if (cmd.kind == CMD_APPEND) begin
            state_next = BK_SKIP;
          end else if (cmd.kind == CMD_LOOKUP) begin
            state_next = BK_READ;
          end
        end
      end
      BK_SKIP: begin
        if (!exhausted) begin
          state_next = BK_IDLE;
        end
      end
      BK_READ: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // control and result
  always_comb begin
    cmd_take    = 1'b0;
    do_clear    = 1'b0;
    do_set      = 1'b0;
    rd_en       = 1'b0;
    advance     = 1'b0;
    assign_code = 1'b0;
    res_load    = 1'b0;
    res_next    = '{code_bits: 16'd0, code_length: 5'd0, status: STATUS_OK};
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && res_free) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            CMD_CLEAR: begin
              do_clear = 1'b1;
              res_load = 1'b1;
            end
            CMD_SET_COUNT: begin
              do_set   = 1'b1;
              res_load = 1'b1;
            end
            CMD_REJECT: begin
              res_load        = 1'b1;
              res_next.status = STATUS_NOT_FOUND;
            end
            CMD_LOOKUP: rd_en = 1'b1;
            CMD_APPEND: ;
            default:    res_load = 1'b1;
          endcase
        end
      end
      BK_SKIP: begin
        if (exhausted) begin
          advance = 1'b1;
        end else begin
          res_load = 1'b1;
          if (overfull) begin
            res_next.status = STATUS_OVERFULL;
          end else begin
            assign_code          = 1'b1;
            res_next.code_bits   = next_code[15:0];
            res_next.code_length = cur_len;
          end
        end
      end
      BK_READ: begin
        res_load = 1'b1;
        if (rd_hit) begin
          res_next.code_bits   = rd_entry[15:0];
          res_next.code_length = rd_entry[20:16];
        end else begin
          res_next.status = STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // canonical code walk state
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      counts     <= '{default: '0};
      cur_len    <= 5'd1;
      used       <= 8'd0;
      next_code  <= 17'd0;
      valid_bits <= '0;
    end else begin
      if (do_set) begin
        counts[LEN_IDX_W'(cmd.length_index - 5'd1)] <= cmd.count_value;
      end
      if (advance) begin
        cur_len <= cur_len + 5'd1;
        used    <= 8'd0;
        if (cur_len < 5'(MAX_CODE_LENGTH)) begin
          next_code <= {next_code[15:0], 1'b0};
        end
      end
      if (assign_code) begin
        used                <= used + 8'd1;
        next_code           <= next_code + 17'd1;
        valid_bits[sym_reg] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      sym_reg <= cmd.symbol_value[SYM_W-1:0];
    end
    if (rd_en) begin
      rd_hit <= valid_bits[cmd.symbol_value[SYM_W-1:0]];
    end
  end

  // code store
  always_ff @(posedge clk) begin
    if (assign_code) begin
      mem[sym_reg] <= {cur_len, next_code[15:0]};
    end
    if (rd_en) begin
      rd_entry <= mem[cmd.symbol_value[SYM_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

  assign empty         = !res_valid;
  assign stat.skipping = (state == BK_SKIP);
  assign stat.reading  = (state == BK_READ);
  assign stat.cur_len  = cur_len;

endmodule

### hw/rtl/canonical_huffman_table_builder.sv
// canonical_huffman_table_builder: top level of the jpeg-style code table builder
// depends on chtb_pkg, chtb_front, chtb_back (and chtb_queue below the front)
//
// usage
//   request side is a queue write port: a beat is taken when push is high and
//   full is low. each beat is one operation: clear, set count for a length,
//   append the next symbol in table order, or look up a symbol's code.
//   result side is a queue read port: while empty is low the oldest result
//   sits on result, and a beat leaves when pop is high. every request gives
//   exactly one result, in request order.
//   the front classifies beats into a two-entry command queue; the back runs
//   them and owns a single result register, so new requests are taken while
//   a result waits.
//   with the back idle, clear, set count and refused symbols post their result
//   as soon as the back takes them; a lookup adds the registered code store
//   read (BK_READ); an append walks BK_SKIP past the used-up lengths, one
//   length per cycle, at most MAX_CODE_LENGTH of them, then posts its code.
//   the back takes one clear or set count beat per cycle while results are
//   popped; it takes no new command until a lookup read or an append walk
//   is done, so lookups and appends are bounded by the read and skip walk.
//   if pop stays low the result holds, the back stops once its register is
//   full, and full rises after two more commands are queued.
//   reset (and the clear operation) zeros the counts, rewinds the code walk to
//   length 1 and drops all store valid flags at once; no sweep needed.

module canonical_huffman_table_builder #(
  parameter int MAX_CODE_LENGTH = chtb_pkg::DEF_MAX_CODE_LENGTH,
  parameter int SYMBOL_COUNT    = chtb_pkg::DEF_SYMBOL_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  chtb_pkg::request_t request,
  output logic               empty,
  input  logic               pop,
  output chtb_pkg::result_t  result
);
  import chtb_pkg::*;

  // front to back command handoff
  cmd_t         cmd;
  logic         cmd_valid;
  logic         cmd_take;
  back_status_t bk_stat;

  chtb_front #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .SYMBOL_COUNT    (SYMBOL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // back runs one command at a time and posts its result beat
  chtb_back #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .SYMBOL_COUNT    (SYMBOL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .stat      (bk_stat)
  );

  // an append walk only runs while the result register is free
  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    bk_stat.skipping |-> empty)
    else $error("append walk running while a result is pending");

  // a lookup read always posts its result the next cycle
  a_read_posts: assert property (@(posedge clk) disable iff (rst)
    bk_stat.reading |=> !empty)
    else $error("lookup read did not post a result");

  // the walk length stays within one past the longest code
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (bk_stat.cur_len >= 5'd1) && (bk_stat.cur_len <= 5'(MAX_CODE_LENGTH + 1)))
    else $error("code length walk out of range");

  // nothing is taken from an empty command queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

### test/canonical_huffman_table_builder_test.sv
`timescale 1ns / 1ps
// canonical_huffman_table_builder_test: self-checking bench for the code table builder
// depends on chtb_pkg and canonical_huffman_table_builder; drives both queue ports
// at random rates and checks every result beat against an in-bench table model or typed-in answer

module canonical_huffman_table_builder_test;
  import chtb_pkg::*;

  localparam int TOTAL_ITEMS  = 1975;       // directed rows plus random requests
  localparam int HOLD_AT      = 1400;       // accepted count that starts the long pop stall
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 24;         // idle wait after the last awaited result
  localparam int MAX_LEN      = DEF_MAX_CODE_LENGTH;
  localparam longint LIMIT_NS = 64'd5_000_000;

  // one row of the directed stimulus; answer is typed in only where fixed is set
  typedef struct packed {
    request_t   req;
    logic       fixed;
    result_t    answer;
  } directed_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  request_t request = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result;

  // what travels with the request being offered, read by the monitor on acceptance
  logic     fixed_valid = 1'b0;
  result_t  fixed_answer = '0;

  int send_idle_pct = 14;
  int recv_idle_pct = 67;
  int issued_requests = 0;
  int accepted_requests = 0;
  int mismatch_count = 0;

  result_t       awaited_answers [$];
  directed_row_t directed_rows [$];

  // table model state
  logic [7:0]  model_counts [1:MAX_LEN];
  int          walk_len;                  // length now being handed out, 17 once past the end
  logic [7:0]  walk_used;                 // codes already given at walk_len
  logic [16:0] walk_code;                 // running canonical code
  logic        store_valid [0:255];
  logic [4:0]  store_len [0:255];
  logic [15:0] store_code [0:255];

  canonical_huffman_table_builder dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void clear_huff_model();
    for (int i = 1; i <= MAX_LEN; i++) model_counts[i] = '0;
    for (int s = 0; s < 256; s++) store_valid[s] = 1'b0;
    walk_len  = 1;
    walk_used = '0;
    walk_code = '0;
  endfunction

  // answer the model gives for one request, updating its state
  function result_t huffman_table_answer(input request_t req);
    result_t ans;
    ans = '0;
    ans.status = STATUS_OK;
    case (req.operation)
      OP_CLEAR: begin
        clear_huff_model();
      end
      OP_SET_COUNT: begin
        // length 0 and lengths past the maximum are dropped silently
        if (req.length_index >= 1 && req.length_index <= MAX_LEN)
          model_counts[req.length_index] = req.count_value;
      end
      OP_APPEND: begin
        // step past used-up lengths, one left shift per longer length
        while (walk_len <= MAX_LEN && walk_used >= model_counts[walk_len]) begin
          walk_len++;
          if (walk_len <= MAX_LEN) walk_code = walk_code << 1;
          walk_used = '0;
        end
        if (walk_len > MAX_LEN || walk_code >= (17'd1 << walk_len)) begin
          ans.status = STATUS_OVERFULL;
        end else begin
          store_valid[req.symbol_value] = 1'b1;
          store_len[req.symbol_value]   = walk_len[4:0];
          store_code[req.symbol_value]  = walk_code[15:0];
          ans.code_bits   = walk_code[15:0];
          ans.code_length = walk_len[4:0];
          walk_code = walk_code + 17'd1;
          walk_used = walk_used + 8'd1;
        end
      end
      default: begin
        if (store_valid[req.symbol_value]) begin
          ans.code_bits   = store_code[req.symbol_value];
          ans.code_length = store_len[req.symbol_value];
        end else begin
          ans.status = STATUS_NOT_FOUND;
        end
      end
    endcase
    return ans;
  endfunction

  function directed_row_t make_row(input logic [1:0] op, input logic [4:0] len_idx,
                                   input logic [7:0] cnt, input logic [7:0] sym,
                                   input logic fixed, input logic [1:0] st,
                                   input logic [15:0] code, input logic [4:0] len);
    directed_row_t row;
    row.req.operation        = op;
    row.req.length_index     = len_idx;
    row.req.count_value      = cnt;
    row.req.symbol_value     = sym;
    row.fixed                = fixed;
    row.answer.status        = st;
    row.answer.code_bits     = code;
    row.answer.code_length   = len;
    return row;
  endfunction

  // monitor: result beats are checked first, then the accepted request is predicted
  always @(posedge clk) begin
    result_t model_ans;
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (awaited_answers.size() == 0) begin
          $error("result beat with nothing awaited: code %h len %0d status %0d",
                 result.code_bits, result.code_length, result.status);
          mismatch_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (result.code_bits !== want.code_bits) begin
            $error("code_bits: expected %h, got %h", want.code_bits, result.code_bits);
            mismatch_count++;
          end
          if (result.code_length !== want.code_length) begin
            $error("code_length: expected %0d, got %0d", want.code_length, result.code_length);
            mismatch_count++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatch_count++;
          end
        end
      end
      if (push && !full) begin
        model_ans = huffman_table_answer(request);
        // typed-in rows override the model so both agree by construction only if correct
        awaited_answers.push_back(fixed_valid ? fixed_answer : model_ans);
        accepted_requests++;
      end
    end
  end

  // offer one request beat; idles before it at the current sender rate
  task automatic offer_request(input request_t req, input logic fixed, input result_t ans);
    // thirds of the run: receiver slow, then sender slow, then both flat out
    if (issued_requests < TOTAL_ITEMS / 3) begin
      send_idle_pct = 14;
      recv_idle_pct = 67;
    end else if (issued_requests < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 14;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    request      <= req;
    fixed_valid  <= fixed;
    fixed_answer <= ans;
    do begin
      @(posedge clk);
    end while (full);
    issued_requests++;
  endtask

  // one table load: optional clear, counts, appends, then lookups, with some noise
  task automatic run_table_session();
    request_t   req;
    logic [7:0] appended [$];
    logic [22:0] raw;
    int pick;
    if ($urandom_range(0, 7) != 0) begin
      req = '0;
      req.operation = OP_CLEAR;
      req.symbol_value = 8'($urandom_range(0, 255));
      offer_request(req, 1'b0, '0);
    end
    repeat ($urandom_range(1, 6)) begin
      raw = 23'($urandom);
      req = raw;
      req.operation = OP_SET_COUNT;
      pick = $urandom_range(0, 19);
      if (pick == 0) req.length_index = 5'd0;
      else if (pick == 1) req.length_index = 5'($urandom_range(MAX_LEN + 1, 31));
      else req.length_index = 5'($urandom_range(1, MAX_LEN));
      // mostly short realistic counts, sometimes anything
      if ($urandom_range(0, 9) != 0) req.count_value = 8'($urandom_range(0, 5));
      offer_request(req, 1'b0, '0);
    end
    repeat ($urandom_range(1, 12)) begin
      raw = 23'($urandom);
      req = raw;
      req.operation = OP_APPEND;
      // reuse a symbol now and then to exercise overwrite
      if (appended.size() != 0 && $urandom_range(0, 9) == 0)
        req.symbol_value = appended[$urandom_range(0, appended.size() - 1)];
      appended.push_back(req.symbol_value);
      offer_request(req, 1'b0, '0);
    end
    repeat ($urandom_range(1, 10)) begin
      raw = 23'($urandom);
      req = raw;
      req.operation = OP_LOOKUP;
      if ($urandom_range(0, 2) != 0)
        req.symbol_value = appended[$urandom_range(0, appended.size() - 1)];
      offer_request(req, 1'b0, '0);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        raw = 23'($urandom);
        req = raw;
        offer_request(req, 1'b0, '0);
      end
    end
  endtask

  // receiver: random pops, plus one long stall while the sender keeps pushing
  initial begin
    int hold_left;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_requests >= HOLD_AT) begin
        pop <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
        hold_done = 1'b1;
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    directed_row_t row;
    clear_huff_model();

    // empty store, empty counts, then ignored length indexes
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'd0,   1, STATUS_NOT_FOUND, 0, 0));
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'd255, 1, STATUS_NOT_FOUND, 0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'd0,   1, STATUS_OVERFULL,  0, 0));
    directed_rows.push_back(make_row(OP_CLEAR,     5'd0,  8'd0,   8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd0,  8'd255, 8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd17, 8'd255, 8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd31, 8'd255, 8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'd1,   1, STATUS_OVERFULL,  0, 0));
    directed_rows.push_back(make_row(OP_CLEAR,     5'd0,  8'd0,   8'd0,   1, STATUS_OK,        0, 0));
    // three codes asked of length one: two fit, the third runs out of room
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd1,  8'd3,   8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'd0,   1, STATUS_OK,        0, 1));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'd255, 1, STATUS_OK,        1, 1));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'd7,   1, STATUS_OVERFULL,  0, 0));
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'd255, 1, STATUS_OK,        1, 1));
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'd7,   1, STATUS_NOT_FOUND, 0, 0));
    directed_rows.push_back(make_row(OP_CLEAR,     5'd0,  8'd0,   8'd0,   1, STATUS_OK,        0, 0));
    // longest length, skipping across, repeated symbol, count withdrawn
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd16, 8'd255, 8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd2,  8'd1,   8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'h80,  0, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'h80,  0, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'h80,  0, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'h55,  0, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_SET_COUNT, 5'd16, 8'd0,   8'd0,   1, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_APPEND,    5'd0,  8'd0,   8'hAA,  0, STATUS_OK,        0, 0));
    directed_rows.push_back(make_row(OP_LOOKUP,    5'd0,  8'd0,   8'h55,  0, STATUS_OK,        0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_request(row.req, row.fixed, row.answer);
    end

    while (issued_requests < TOTAL_ITEMS) run_table_session();

    @(negedge clk);
    push <= 1'b0;
    fixed_valid <= 1'b0;

    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
